// File: rtl/core/fsp_pkg.sv
// ---------------------------------------------------------------------------
// fsp_pkg: frame set parser shared types and constants
// Parse phases, result kinds, the result record and the flag decode helpers.
// ---------------------------------------------------------------------------
package fsp_pkg;

   typedef enum logic [3:0] {
      PH_ID    = 4'd0,
      PH_SEQ   = 4'd1,
      PH_FLAGS = 4'd2,
      PH_LEN   = 4'd3,
      PH_REL   = 4'd4,
      PH_SQD   = 4'd5,
      PH_ORD   = 4'd6,
      PH_CHAN  = 4'd7,
      PH_FCNT  = 4'd8,
      PH_FID   = 4'd9,
      PH_FIDX  = 4'd10,
      PH_PAY   = 4'd11
   } phase_type;

   localparam logic [2:0] KIND_HEADER      = 3'd0;
   localparam logic [2:0] KIND_FRAG_HEADER = 3'd1;
   localparam logic [2:0] KIND_PAYLOAD     = 3'd2;
   localparam logic [2:0] KIND_OK          = 3'd3;
   localparam logic [2:0] KIND_TRUNCATED   = 3'd4;

   localparam logic [7:0]  REL_MASK  = 8'b1110_0000;
   localparam logic [7:0]  FRAG_MASK = 8'b0001_0000;
   localparam logic [16:0] ROUND_UP  = 17'd7;

   typedef struct packed {
      logic [2:0]  kind;
      logic [23:0] set_sequence;
      logic [2:0]  reliability;
      logic [15:0] payload_bits;
      logic [23:0] reliable_index;
      logic [23:0] sequenced_index;
      logic [23:0] ordered_index;
      logic [7:0]  order_channel;
      logic [31:0] compound_size;
      logic [15:0] compound_id;
      logic [31:0] fragment_index;
      logic [7:0]  payload_data;
   } result_type;

   function automatic logic [2:0] rel_class(input logic [7:0] flags);
      logic [7:0] m;
      m = flags & REL_MASK;
      return m[7:5];
   endfunction

   function automatic logic has_reliable(input logic [7:0] flags);
      logic [2:0] r;
      r = rel_class(flags);
      return (r == 3'd2) || (r == 3'd3) || (r == 3'd4) || (r == 3'd6) || (r == 3'd7);
   endfunction

   function automatic logic has_sequenced(input logic [7:0] flags);
      logic [2:0] r;
      r = rel_class(flags);
      return (r == 3'd1) || (r == 3'd4);
   endfunction

   function automatic logic has_ordered(input logic [7:0] flags);
      logic [2:0] r;
      r = rel_class(flags);
      return (r == 3'd1) || (r == 3'd3) || (r == 3'd4) || (r == 3'd7);
   endfunction

   function automatic logic has_fragment(input logic [7:0] flags);
      return (flags & FRAG_MASK) != 8'd0;
   endfunction

   // first present field after phase p, PH_PAY when the header is complete
   function automatic phase_type next_field(input phase_type p, input logic [7:0] flags);
      phase_type n;
      if (p < PH_REL && has_reliable(flags)) n = PH_REL;
      else if (p < PH_SQD && has_sequenced(flags)) n = PH_SQD;
      else if (p < PH_ORD && has_ordered(flags)) n = PH_ORD;
      else if (p < PH_CHAN && has_ordered(flags)) n = PH_CHAN;
      else if (p < PH_FCNT && has_fragment(flags)) n = PH_FCNT;
      else if (p < PH_FID && has_fragment(flags)) n = PH_FID;
      else if (p < PH_FIDX && has_fragment(flags)) n = PH_FIDX;
      else n = PH_PAY;
      return n;
   endfunction

   // little-endian 24-bit insert of byte b at byte position pos
   function automatic logic [23:0] le24(input logic [23:0] old, input logic [7:0] b,
                                        input logic [1:0] pos);
      logic [23:0] v;
      v = old;
      case (pos)
         2'd0: v[7:0]   = v[7:0] | b;
         2'd1: v[15:8]  = v[15:8] | b;
         2'd2: v[23:16] = v[23:16] | b;
         default: v = old;
      endcase
      return v;
   endfunction

endpackage

// File: rtl/core/frame_set_parser.sv
// ---------------------------------------------------------------------------
// frame_set_parser: frame set datagram parser
// Takes one datagram byte per transaction and returns frame headers, payload
// bytes and an end of datagram status as result transactions.
// ---------------------------------------------------------------------------
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | data_byte, end_of_datagram
//   rsp     | out       | rsp_valid/rsp_stall  | kind and frame fields
//
// One byte per cycle is accepted while req_stall is low; the byte is decoded
// in the same cycle and its results are written into a three entry result
// queue. A byte giving two results (last header or payload byte with end of
// datagram) yields two output transactions; req_stall rises while the queue
// cannot hold two more results.
// Reset clears the parse state and empties the queue.
module frame_set_parser
   import fsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_datagram,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [23:0] rsp_set_sequence,
   output logic [2:0]  rsp_reliability,
   output logic [15:0] rsp_payload_bits,
   output logic [23:0] rsp_reliable_index,
   output logic [23:0] rsp_sequenced_index,
   output logic [23:0] rsp_ordered_index,
   output logic [7:0]  rsp_order_channel,
   output logic [31:0] rsp_compound_size,
   output logic [15:0] rsp_compound_id,
   output logic [31:0] rsp_fragment_index,
   output logic [7:0]  rsp_payload_data
);

   result_type q_ff [3];
   result_type q_in [3];
   logic [1:0] count_ff, count_in, count_left;
   logic       pop, take;
   result_type res0, res1;
   logic [1:0] res_count;

   assign pop        = rsp_valid && !rsp_stall;
   assign count_left = pop ? count_ff - 2'd1 : count_ff;
   assign req_stall  = (count_left > 2'd1);
   assign take       = req_valid && !req_stall;

   fsp_parser u_parser (
      .clock           (clock),
      .reset           (reset),
      .take            (take),
      .data_byte       (req_data_byte),
      .end_of_datagram (req_end_of_datagram),
      .res0            (res0),
      .res1            (res1),
      .res_count       (res_count)
   );

   always_comb begin
      q_in     = q_ff;
      count_in = count_left;
      if (pop) begin
         q_in[0] = q_ff[1];
         q_in[1] = q_ff[2];
      end
      if (take) begin
         if (res_count != 2'd0) q_in[count_left] = res0;
         if (res_count == 2'd2) q_in[count_left + 2'd1] = res1;
         count_in = count_left + res_count;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign rsp_valid           = (count_ff != 2'd0);
   assign rsp_kind            = q_ff[0].kind;
   assign rsp_set_sequence    = q_ff[0].set_sequence;
   assign rsp_reliability     = q_ff[0].reliability;
   assign rsp_payload_bits    = q_ff[0].payload_bits;
   assign rsp_reliable_index  = q_ff[0].reliable_index;
   assign rsp_sequenced_index = q_ff[0].sequenced_index;
   assign rsp_ordered_index   = q_ff[0].ordered_index;
   assign rsp_order_channel   = q_ff[0].order_channel;
   assign rsp_compound_size   = q_ff[0].compound_size;
   assign rsp_compound_id     = q_ff[0].compound_id;
   assign rsp_fragment_index  = q_ff[0].fragment_index;
   assign rsp_payload_data    = q_ff[0].payload_data;

endmodule

// File: rtl/core/fsp_parser.sv
// ---------------------------------------------------------------------------
// fsp_parser: byte-serial frame set field decoder
// Tracks the parse phase and held fields, and forms up to two results per byte.
// ---------------------------------------------------------------------------
module fsp_parser
   import fsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       take,
   input  logic [7:0] data_byte,
   input  logic       end_of_datagram,
   output result_type res0,
   output result_type res1,
   output logic [1:0] res_count
);

   phase_type   phase_ff, phase_in;
   logic [2:0]  cnt_ff, cnt_in, cnt_inc;
   logic [7:0]  flags_ff, flags_in;
   logic [23:0] seq_ff, seq_in;
   logic [15:0] len_ff, len_in;
   logic [23:0] rel_ff, rel_in;
   logic [23:0] sqd_ff, sqd_in;
   logic [23:0] ord_ff, ord_in;
   logic [7:0]  chan_ff, chan_in;
   logic [31:0] fcnt_ff, fcnt_in;
   logic [15:0] fid_ff, fid_in;
   logic [31:0] fidx_ff, fidx_in;
   logic [13:0] rem_ff, rem_in, rem_dec;
   logic [16:0] rem_sum;
   phase_type   adv_phase;
   logic        adv, hdr_done, pay_byte, eod_hit, eod_ok;
   result_type  first_res, eod_res;

   assign cnt_inc = cnt_ff + 3'd1;
   assign rem_dec = (rem_ff != 14'd0) ? rem_ff - 14'd1 : rem_ff;
   assign rem_sum = {1'b0, len_in} + ROUND_UP;

   always_comb begin
      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      flags_in  = flags_ff;
      seq_in    = seq_ff;
      len_in    = len_ff;
      rel_in    = rel_ff;
      sqd_in    = sqd_ff;
      ord_in    = ord_ff;
      chan_in   = chan_ff;
      fcnt_in   = fcnt_ff;
      fid_in    = fid_ff;
      fidx_in   = fidx_ff;
      rem_in    = rem_ff;
      adv       = 1'b0;
      hdr_done  = 1'b0;
      pay_byte  = 1'b0;
      eod_hit   = 1'b0;
      eod_ok    = 1'b0;
      adv_phase = next_field(phase_ff, flags_ff);
      if (take) begin
         unique case (phase_ff)
            PH_ID: begin
               seq_in   = 24'd0;
               cnt_in   = 3'd0;
               phase_in = PH_SEQ;
            end
            PH_SEQ: begin
               seq_in = le24(seq_ff, data_byte, cnt_ff[1:0]);
               cnt_in = cnt_inc;
               if (cnt_inc >= 3'd3) begin
                  cnt_in   = 3'd0;
                  phase_in = PH_FLAGS;
               end
            end
            PH_FLAGS: begin
               flags_in = data_byte;
               len_in   = 16'd0;
               rel_in   = 24'd0;
               sqd_in   = 24'd0;
               ord_in   = 24'd0;
               chan_in  = 8'd0;
               fcnt_in  = 32'd0;
               fid_in   = 16'd0;
               fidx_in  = 32'd0;
               cnt_in   = 3'd0;
               phase_in = PH_LEN;
            end
            PH_LEN: begin
               len_in = {len_ff[7:0], data_byte};
               cnt_in = cnt_inc;
               adv    = (cnt_inc >= 3'd2);
            end
            PH_REL: begin
               rel_in = le24(rel_ff, data_byte, cnt_ff[1:0]);
               cnt_in = cnt_inc;
               adv    = (cnt_inc >= 3'd3);
            end
            PH_SQD: begin
               sqd_in = le24(sqd_ff, data_byte, cnt_ff[1:0]);
               cnt_in = cnt_inc;
               adv    = (cnt_inc >= 3'd3);
            end
            PH_ORD: begin
               ord_in = le24(ord_ff, data_byte, cnt_ff[1:0]);
               cnt_in = cnt_inc;
               adv    = (cnt_inc >= 3'd3);
            end
            PH_CHAN: begin
               chan_in = data_byte;
               adv     = 1'b1;
            end
            PH_FCNT: begin
               fcnt_in = {fcnt_ff[23:0], data_byte};
               cnt_in  = cnt_inc;
               adv     = (cnt_inc >= 3'd4);
            end
            PH_FID: begin
               fid_in = {fid_ff[7:0], data_byte};
               cnt_in = cnt_inc;
               adv    = (cnt_inc >= 3'd2);
            end
            PH_FIDX: begin
               fidx_in = {fidx_ff[23:0], data_byte};
               cnt_in  = cnt_inc;
               adv     = (cnt_inc >= 3'd4);
            end
            PH_PAY: begin
               pay_byte = 1'b1;
               rem_in   = rem_dec;
               if (rem_dec == 14'd0) phase_in = PH_FLAGS;
            end
            default: begin
               phase_in = PH_ID;
               cnt_in   = 3'd0;
            end
         endcase
         if (adv) begin
            cnt_in = 3'd0;
            if (adv_phase == PH_PAY) begin
               hdr_done = 1'b1;
               rem_in   = rem_sum[16:3];
               phase_in = (rem_sum[16:3] != 14'd0) ? PH_PAY : PH_FLAGS;
            end else begin
               phase_in = adv_phase;
            end
         end
         if (end_of_datagram) begin
            eod_hit  = 1'b1;
            eod_ok   = (phase_in == PH_FLAGS);
            phase_in = PH_ID;
            cnt_in   = 3'd0;
            rem_in   = 14'd0;
         end
      end
   end

   always_comb begin
      first_res = '0;
      eod_res   = '0;
      if (hdr_done) begin
         first_res.kind            = has_fragment(flags_ff) ? KIND_FRAG_HEADER : KIND_HEADER;
         first_res.set_sequence    = seq_ff;
         first_res.reliability     = rel_class(flags_ff);
         first_res.payload_bits    = len_in;
         first_res.reliable_index  = rel_in;
         first_res.sequenced_index = sqd_in;
         first_res.ordered_index   = ord_in;
         first_res.order_channel   = chan_in;
         first_res.compound_size   = fcnt_in;
         first_res.compound_id     = fid_in;
         first_res.fragment_index  = fidx_in;
      end else if (pay_byte) begin
         first_res.kind         = KIND_PAYLOAD;
         first_res.set_sequence = seq_ff;
         first_res.payload_data = data_byte;
      end
      if (eod_ok) begin
         eod_res.kind         = KIND_OK;
         eod_res.set_sequence = seq_in;
      end else begin
         eod_res.kind = KIND_TRUNCATED;
      end
      if (hdr_done || pay_byte) begin
         res0      = first_res;
         res1      = eod_res;
         res_count = eod_hit ? 2'd2 : 2'd1;
      end else begin
         res0      = eod_res;
         res1      = eod_res;
         res_count = eod_hit ? 2'd1 : 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_ID;
         cnt_ff   <= 3'd0;
         flags_ff <= 8'd0;
         seq_ff   <= 24'd0;
         len_ff   <= 16'd0;
         rel_ff   <= 24'd0;
         sqd_ff   <= 24'd0;
         ord_ff   <= 24'd0;
         chan_ff  <= 8'd0;
         fcnt_ff  <= 32'd0;
         fid_ff   <= 16'd0;
         fidx_ff  <= 32'd0;
         rem_ff   <= 14'd0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         flags_ff <= flags_in;
         seq_ff   <= seq_in;
         len_ff   <= len_in;
         rel_ff   <= rel_in;
         sqd_ff   <= sqd_in;
         ord_ff   <= ord_in;
         chan_ff  <= chan_in;
         fcnt_ff  <= fcnt_in;
         fid_ff   <= fid_in;
         fidx_ff  <= fidx_in;
         rem_ff   <= rem_in;
      end
   end

endmodule
